### hw/rtl/aigd_pkg.sv
`default_nettype none

package aigd_pkg;

	// Widths fixed by the stream format.
	localparam int OUT_W      = 32;
	localparam int CNT_W      = 28;
	localparam int CFG_IDX_W  = 2;
	localparam int STATUS_W   = 2;
	localparam int GROUP_BITS = 7;

	localparam int DEFAULT_LITERAL_WIDTH = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_COUNT = 2'd0,
		REG_LATCH_COUNT = 2'd1,
		REG_AND_COUNT   = 2'd2
	} cfg_reg_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_DELTA_BIG = 2'd1,
		STATUS_OVERFLOW  = 2'd2,
		STATUS_EARLY_END = 2'd3
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0] input_count;
		logic [CNT_W-1:0] latch_count;
		logic [CNT_W-1:0] and_count;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] gate_literal;
		logic [OUT_W-1:0] fanin_first;
		logic [OUT_W-1:0] fanin_second;
		status_t          status;
		logic             last_gate;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/aigd_cfg_regs.sv
`default_nettype none

module aigd_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [aigd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aigd_pkg::CNT_W-1:0]     cfg_data,
	output aigd_pkg::cfg_t                     cfg
);
	import aigd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Writes to an index beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INPUT_COUNT: cfg_q.input_count <= cfg_data;
				REG_LATCH_COUNT: cfg_q.latch_count <= cfg_data;
				REG_AND_COUNT:   cfg_q.and_count   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/aigd_step.sv
`default_nettype none

module aigd_step #(
	parameter int LITERAL_WIDTH = aigd_pkg::DEFAULT_LITERAL_WIDTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic [7:0]     data_byte,
	input  wire logic           end_of_data,
	input  wire aigd_pkg::cfg_t cfg,
	output logic                res_valid,
	output aigd_pkg::result_t   res
);
	import aigd_pkg::*;

	localparam int FULL_GROUPS = LITERAL_WIDTH / GROUP_BITS;
	localparam int IDX_W       = $clog2(FULL_GROUPS + 1);
	localparam int SHA_W       = $clog2(GROUP_BITS * FULL_GROUPS + 1);
	localparam int SH_W        = LITERAL_WIDTH + GROUP_BITS;
	localparam int SUM_W       = CNT_W + 1;
	localparam logic [7:0] TOP_LIMIT = 8'(1 << (LITERAL_WIDTH % GROUP_BITS));

	logic [LITERAL_WIDTH-1:0] partial_q, gate_q, hold_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     phase_q;
	logic [CNT_W-1:0]         left_q;

	logic [LITERAL_WIDTH-1:0] partial_b, gate_b, hold_b, gate_load, new_partial;
	logic [IDX_W-1:0]         idx_b;
	logic                     phase_b, start;
	logic [CNT_W-1:0]         left_b;
	logic [SUM_W-1:0]         base_sum;
	logic [SHA_W-1:0]         shamt;
	logic [SH_W-1:0]          shifted;

	logic [LITERAL_WIDTH-1:0] partial_d, gate_d, hold_d;
	logic [IDX_W-1:0]         idx_d;
	logic                     phase_d;
	logic [CNT_W-1:0]         left_d;
	logic                     emit;
	status_t                  st;
	logic [LITERAL_WIDTH-1:0] f0, f1;
	logic                     last;

	// First gate literal of a run: 2 * (1 + inputs + latches).
	assign base_sum  = SUM_W'(cfg.input_count) + SUM_W'(cfg.latch_count) + SUM_W'(1);
	assign gate_load = LITERAL_WIDTH'({base_sum, 1'b0});

	assign start     = (left_q == '0);
	assign gate_b    = start ? gate_load : gate_q;
	assign hold_b    = start ? '0 : hold_q;
	assign left_b    = start ? cfg.and_count : left_q;
	assign partial_b = start ? '0 : partial_q;
	assign idx_b     = start ? '0 : idx_q;
	assign phase_b   = start ? 1'b0 : phase_q;

	assign shamt       = SHA_W'(idx_b) * SHA_W'(GROUP_BITS);
	assign shifted     = SH_W'(data_byte[6:0]) << shamt;
	assign new_partial = partial_b | shifted[LITERAL_WIDTH-1:0];

	always_comb begin
		partial_d = partial_b;
		idx_d     = idx_b;
		phase_d   = phase_b;
		gate_d    = gate_b;
		hold_d    = hold_b;
		left_d    = left_b;
		emit      = 1'b0;
		st        = STATUS_OK;
		f0        = phase_b ? hold_b : '0;
		f1        = '0;
		last      = 1'b0;
		if (left_b == '0) begin
			// Empty run: the item is dropped.
			emit = 1'b0;
		end else if (end_of_data) begin
			emit = 1'b1;
			st   = STATUS_EARLY_END;
		end else if (idx_b >= IDX_W'(FULL_GROUPS) && data_byte >= TOP_LIMIT) begin
			emit = 1'b1;
			st   = STATUS_OVERFLOW;
		end else if (data_byte[7]) begin
			partial_d = new_partial;
			idx_d     = idx_b + IDX_W'(1);
		end else begin
			partial_d = '0;
			idx_d     = '0;
			if (!phase_b) begin
				if (new_partial > gate_b) begin
					emit = 1'b1;
					st   = STATUS_DELTA_BIG;
				end else begin
					hold_d  = gate_b - new_partial;
					phase_d = 1'b1;
				end
			end else if (new_partial > hold_b) begin
				emit = 1'b1;
				st   = STATUS_DELTA_BIG;
			end else begin
				emit    = 1'b1;
				f1      = hold_b - new_partial;
				last    = (left_b == CNT_W'(1));
				phase_d = 1'b0;
				left_d  = left_b - CNT_W'(1);
				gate_d  = gate_b + LITERAL_WIDTH'(2);
			end
		end
		// Any error sends the decoder back to the start of a run.
		if (emit && st != STATUS_OK) begin
			partial_d = '0;
			idx_d     = '0;
			phase_d   = 1'b0;
			left_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			idx_q     <= '0;
			phase_q   <= 1'b0;
			gate_q    <= '0;
			hold_q    <= '0;
			left_q    <= '0;
		end else if (fire) begin
			partial_q <= partial_d;
			idx_q     <= idx_d;
			phase_q   <= phase_d;
			gate_q    <= gate_d;
			hold_q    <= hold_d;
			left_q    <= left_d;
		end
	end

	assign res_valid        = emit;
	assign res.gate_literal = OUT_W'(gate_b);
	assign res.fanin_first  = OUT_W'(f0);
	assign res.fanin_second = OUT_W'(f1);
	assign res.status       = st;
	assign res.last_gate    = last;

endmodule

`default_nettype wire

### hw/rtl/aigd_out_reg.sv
`default_nettype none

module aigd_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              res_valid,
	input  wire aigd_pkg::result_t res,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output aigd_pkg::result_t      out_res
);
	import aigd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (space && take && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/aig_binary_and_delta_decoder.sv
// Delta decoder for the and-gate section of a binary and-inverter-graph file.
// Bytes of the gate section enter on the s_axis stream, one item per byte;
// tuser bit 0 flags end of data, in which case the byte is ignored. Each
// decoded gate leaves on the m_axis stream as its gate literal and both fanin
// literals in tdata, a status code in tuser and tlast on the final gate of a
// run. Errors (delta larger than its base, a number too long for the literal
// width, end of data before all gates) leave as one item with a nonzero
// status, after which the decoder waits for a new run.
// The cfg channel writes input_count, latch_count and and_count; they are
// sampled when a run starts, so write them only while the decoder is idle.
// Throughput is one byte per clock cycle while the receiver keeps up: the whole
// step (shift, OR, compare and subtract) sits between the input register and
// the result register. A byte is registered in the input register on accept;
// its result, if any, passes on into the output register. When the receiver
// stalls, the result holds there and the input side keeps accepting until
// the input register also fills. Reset clears all counters, the run state and
// the configuration registers to zero; no item is pending afterwards.
`default_nettype none

module aig_binary_and_delta_decoder #(
	parameter int LITERAL_WIDTH = aigd_pkg::DEFAULT_LITERAL_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  wire logic [0:0]                     s_axis_tuser,  // [0] end_of_data
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [31:0] gate_literal, [63:32] fanin_first, [95:64] fanin_second
	output logic [3*aigd_pkg::OUT_W-1:0]        m_axis_tdata,
	output logic [aigd_pkg::STATUS_W-1:0]       m_axis_tuser,  // [1:0] status
	output logic                                m_axis_tlast,  // last_gate
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [aigd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aigd_pkg::CNT_W-1:0]     cfg_data
);
	import aigd_pkg::*;

	cfg_t    cfg;
	result_t res, out_res;
	logic    res_valid, space, fire;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;

	assign s_axis_tready = !valid_s1 || space;
	assign fire          = valid_s1 && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eod_s1  <= s_axis_tuser[0];
		end
	end

	aigd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aigd_step #(
		.LITERAL_WIDTH (LITERAL_WIDTH)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	aigd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (fire),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.fanin_second, out_res.fanin_first, out_res.gate_literal};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last_gate;

endmodule

`default_nettype wire

### dv/aigd_gate_checker.sv
// Watches the byte, result and register channels of the gate decoder, keeps its
// own model of the decode state and checks every result item in order.
module aigd_gate_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,
	input  logic [0:0]                     s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [3*aigd_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic [aigd_pkg::STATUS_W-1:0]  m_axis_tuser,
	input  logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [aigd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aigd_pkg::CNT_W-1:0]     cfg_data,
	output int                             mismatch_count,
	output int                             gates_pending
);
	import aigd_pkg::*;

	localparam int LIT_W       = DEFAULT_LITERAL_WIDTH;
	localparam int FULL_GROUPS = LIT_W / GROUP_BITS;
	localparam int TOP_LIMIT   = 1 << (LIT_W % GROUP_BITS);

	logic [CNT_W-1:0] cfg_inputs;
	logic [CNT_W-1:0] cfg_latches;
	logic [CNT_W-1:0] cfg_gates;

	logic [LIT_W-1:0] delta_acc;
	logic [2:0]       group_idx;
	logic             in_second;
	logic [LIT_W-1:0] run_gate;
	logic [LIT_W-1:0] held_fanin;
	logic [CNT_W-1:0] gates_to_go;

	result_t gate_queue[$];
	result_t want;

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] exp_val);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
		mismatch_count++;
	endtask

	task automatic push_gate(input logic [LIT_W-1:0] g, input logic [LIT_W-1:0] f0,
			input logic [LIT_W-1:0] f1, input status_t st, input logic last);
		result_t r;
		r.gate_literal = g;
		r.fanin_first  = f0;
		r.fanin_second = f1;
		r.status       = st;
		r.last_gate    = last;
		gate_queue.insert(gate_queue.size(), r);
		gates_pending++;
	endtask

	// Any fault reports the gate in progress and drops back to the run start.
	task automatic flag_fault(input status_t st);
		push_gate(run_gate, in_second ? held_fanin : '0, '0, st, 1'b0);
		delta_acc   = '0;
		group_idx   = '0;
		in_second   = 1'b0;
		gates_to_go = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eod);
		logic [LIT_W-1:0] delta;
		if (gates_to_go == '0) begin
			delta_acc   = '0;
			group_idx   = '0;
			in_second   = 1'b0;
			run_gate    = (LIT_W'(1) + cfg_inputs + cfg_latches) << 1;
			held_fanin  = '0;
			gates_to_go = cfg_gates;
			if (gates_to_go == '0)
				return;
		end
		if (eod) begin
			flag_fault(STATUS_EARLY_END);
			return;
		end
		if (group_idx >= FULL_GROUPS && b >= TOP_LIMIT) begin
			flag_fault(STATUS_OVERFLOW);
			return;
		end
		delta_acc = delta_acc | ({{(LIT_W-7){1'b0}}, b[6:0]} << (GROUP_BITS * group_idx));
		group_idx = group_idx + 3'd1;
		if (b[7])
			return;
		delta     = delta_acc;
		delta_acc = '0;
		group_idx = '0;
		if (!in_second) begin
			if (delta > run_gate) begin
				flag_fault(STATUS_DELTA_BIG);
				return;
			end
			held_fanin = run_gate - delta;
			in_second  = 1'b1;
			return;
		end
		if (delta > held_fanin) begin
			flag_fault(STATUS_DELTA_BIG);
			return;
		end
		push_gate(run_gate, held_fanin, held_fanin - delta, STATUS_OK, gates_to_go == 1);
		in_second   = 1'b0;
		gates_to_go = gates_to_go - 1'b1;
		run_gate    = run_gate + 2;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_inputs     = '0;
			cfg_latches    = '0;
			cfg_gates      = '0;
			delta_acc      = '0;
			group_idx      = '0;
			in_second      = 1'b0;
			run_gate       = '0;
			held_fanin     = '0;
			gates_to_go    = '0;
			gate_queue.delete();
			gates_pending  = 0;
			mismatch_count = 0;
		end else begin
			// The result leaving at this edge always belongs to an earlier byte.
			if (m_axis_tvalid && m_axis_tready) begin
				if (gates_pending == 0) begin
					report_mismatch("result with nothing expected", m_axis_tdata[OUT_W-1:0], '0);
				end else begin
					want = gate_queue.pop_front();
					gates_pending--;
					if (m_axis_tdata[OUT_W-1:0] !== want.gate_literal)
						report_mismatch("gate_literal", m_axis_tdata[OUT_W-1:0],
							want.gate_literal);
					if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.fanin_first)
						report_mismatch("fanin_first", m_axis_tdata[2*OUT_W-1:OUT_W],
							want.fanin_first);
					if (m_axis_tdata[3*OUT_W-1:2*OUT_W] !== want.fanin_second)
						report_mismatch("fanin_second", m_axis_tdata[3*OUT_W-1:2*OUT_W],
							want.fanin_second);
					if (m_axis_tuser !== want.status)
						report_mismatch("status", OUT_W'(m_axis_tuser), OUT_W'(want.status));
					if (m_axis_tlast !== want.last_gate)
						report_mismatch("last_gate", OUT_W'(m_axis_tlast),
							OUT_W'(want.last_gate));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tuser[0]);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INPUT_COUNT: cfg_inputs  = cfg_data;
					REG_LATCH_COUNT: cfg_latches = cfg_data;
					REG_AND_COUNT:   cfg_gates   = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

### dv/aig_binary_and_delta_decoder_tb.sv
// Top of the gate decoder bench. It only makes traffic: register settings,
// gate byte streams and receiver back-pressure. The checker beside the decoder
// predicts and compares, and hands its mismatch count back for the verdict.
module aig_binary_and_delta_decoder_tb;
	import aigd_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	// Past this many random items, neither side idles at random any more.
	localparam int CALM_AFTER   = 1450;
	localparam int LONG_HOLD    = 80;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [7:0] data_byte
	logic [0:0]           s_axis_tuser;   // [0] end_of_data
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [3*OUT_W-1:0]   m_axis_tdata;   // [31:0] gate, [63:32] fanin 1, [95:64] fanin 2
	logic [STATUS_W-1:0]  m_axis_tuser;   // [1:0] status
	logic                 m_axis_tlast;   // last_gate
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	int mismatch_count;
	int gates_pending;

	// Traffic state shared by the sender and the receiver.
	bit calm;
	bit long_hold;
	int items_sent;

	// The sender's own view of the run so that it can build legal deltas.
	logic [31:0]      gen_base;
	logic [CNT_W-1:0] gen_ands;

	aig_binary_and_delta_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	aigd_gate_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.gates_pending  (gates_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver. Ready drops for short random bursts, and once for a long hold
	// that the sender asks for, so that the decoder backs up into its input.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// Offers one byte item and returns at the falling edge after it was taken.
	// Valid is left high; whoever stops sending lowers it.
	task automatic send_item(input logic [7:0] b, input logic eod);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= eod;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Stops the byte stream until every expected result has come out, then
	// waits for the decoder to finish any byte that makes no result.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (gates_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// New register values only while the decoder is idle.
	task automatic set_counts(input logic [CNT_W-1:0] ins, input logic [CNT_W-1:0] lats,
			input logic [CNT_W-1:0] ands);
		drain_results();
		write_reg(REG_INPUT_COUNT, ins);
		write_reg(REG_LATCH_COUNT, lats);
		write_reg(REG_AND_COUNT, ands);
		cfg_valid <= 1'b0;
		gen_base = (32'd1 + ins + lats) << 1;
		gen_ands = ands;
	endtask

	// Seven bits per byte, low group first. Now and then the value is padded
	// with zero groups up to the five byte maximum, which is still legal.
	task automatic send_delta(input logic [31:0] value);
		int n;
		int i;
		logic [6:0] grp;
		n = 1;
		while (n < 5 && (value >> (7 * n)) != 0) n++;
		if ($urandom_range(0, 7) == 0)
			n = $urandom_range(n, 5);
		for (i = 0; i < n; i++) begin
			grp = 7'(value >> (7 * i));
			send_item({(i < n - 1) ? 1'b1 : 1'b0, grp}, 1'b0);
		end
	endtask

	function automatic logic [31:0] pick_delta(input logic [31:0] limit);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return limit;
			2: return $urandom_range(limit, 0);
			default: return $urandom_range((limit < 32'd20000) ? limit : 32'd20000, 0);
		endcase
	endfunction

	function automatic logic [31:0] pick_too_big(input logic [31:0] limit);
		if ($urandom_range(0, 1) == 0)
			return limit + 1;
		return $urandom_range(32'hFFFF_FFFF, limit + 1);
	endfunction

	// Four continuation bytes fill the 28 low bits; a fifth byte of 16 or more
	// cannot fit in a 32 bit literal.
	task automatic send_overflow();
		repeat (4) send_item(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
		send_item(8'($urandom_range(16, 255)), 1'b0);
	endtask

	task automatic send_good_gate(input logic [31:0] g);
		logic [31:0] d1;
		d1 = pick_delta(g);
		send_delta(d1);
		send_delta(pick_delta(g - d1));
	endtask

	// Ends the run in progress with one of the three faults, placed at
	// various points within the gate.
	task automatic send_fault(input logic [31:0] g);
		logic [31:0] d1;
		d1 = pick_delta(g);
		case ($urandom_range(0, 6))
			0: send_delta(pick_too_big(g));
			1: begin
				send_delta(d1);
				send_delta(pick_too_big(g - d1));
			end
			2: send_overflow();
			3: begin
				send_delta(d1);
				send_overflow();
			end
			4: send_item(8'($urandom_range(0, 255)), 1'b1);
			5: begin
				if ($urandom_range(0, 1) == 0)
					send_delta(d1);
				repeat ($urandom_range(1, 4)) send_item(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				send_delta(d1);
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	// One run from the start: either every gate of and_count, or a few gates
	// followed by a fault. Large gate counts always end with a fault.
	task automatic send_run();
		int n_good;
		int k;
		bit ends_bad;
		logic [31:0] g;
		if (gen_ands <= 12 && $urandom_range(0, 3) != 0) begin
			n_good   = int'(gen_ands);
			ends_bad = 1'b0;
		end else begin
			n_good   = $urandom_range(0, (gen_ands < 6) ? int'(gen_ands) - 1 : 5);
			ends_bad = 1'b1;
		end
		g = gen_base;
		for (k = 0; k < n_good; k++) begin
			send_good_gate(g);
			g = g + 2;
		end
		if (ends_bad)
			send_fault(g);
	endtask

	// Random bytes with no structure. The closing end-of-data item always
	// puts the decoder back at the start of a run, whatever the bytes did.
	task automatic send_noise();
		repeat ($urandom_range(1, 12))
			send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int phase;
		logic [CNT_W-1:0] ins;
		logic [CNT_W-1:0] lats;
		logic [CNT_W-1:0] ands;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_INPUT_COUNT;
		cfg_data      = '0;
		calm          = 1'b0;
		long_hold     = 1'b0;
		items_sent    = 0;
		gen_base      = 32'd2;
		gen_ands      = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: two gates from literal 2 with the smallest deltas and one
		// full-size delta, then each fault in turn. Every fault leaves the decoder at a run start.
		set_counts('0, '0, 28'd2);
		send_delta(32'd0);
		send_delta(32'd0);
		send_delta(32'd4);
		send_delta(32'd0);
		// End of data before the first byte of a run.
		send_item(8'hFF, 1'b1);
		// First delta one above the gate literal.
		send_delta(32'd3);
		// Second delta larger than the first fanin.
		send_delta(32'd1);
		send_delta(32'd2);
		// Fifth byte too large, in the first and in the second delta.
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h10, 1'b0);
		send_delta(32'd2);
		send_item(8'h80, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b0);
		// End of data in the middle of a delta.
		send_item(8'h81, 1'b0);
		send_item(8'h00, 1'b1);
		// All-ones delta in five bytes: legal length, but larger than any gate.
		send_delta(32'hFFFF_FFFF);

		// Largest header counts: a full-range first delta down to literal 0.
		set_counts(CNT_MAX, CNT_MAX, CNT_MAX);
		send_delta(gen_base);
		send_delta(32'd0);
		send_item(8'h00, 1'b1);

		// With no gates to decode every byte is dropped without a result.
		set_counts(CNT_MAX, '0, '0);
		send_item(8'h7F, 1'b0);
		send_item(8'h80, 1'b1);
		send_item(8'h00, 1'b0);

		// Random part: a new register setting per phase, several runs each.
		items_sent = 0;
		phase      = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin
					ins  = CNT_MAX;
					lats = CNT_MAX;
				end
				1: begin
					ins  = '0;
					lats = '0;
				end
				2: begin
					ins  = CNT_W'($urandom);
					lats = CNT_W'($urandom);
				end
				default: begin
					ins  = CNT_W'($urandom_range(0, 50));
					lats = CNT_W'($urandom_range(0, 50));
				end
			endcase
			case ($urandom_range(0, 9))
				0: ands = CNT_MAX;
				1: ands = CNT_W'($urandom) | 28'd1;
				default: ands = CNT_W'($urandom_range(1, 6));
			endcase
			set_counts(ins, lats, ands);
			// Once, hold the result side for a long stretch while bytes keep
			// coming, so that the decoder fills and stalls its input.
			if (phase == 1)
				long_hold = 1'b1;
			repeat ($urandom_range(4, 12)) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					send_run();
				// Now and then the sender waits for every result to come back.
				if ($urandom_range(0, 15) == 0)
					drain_results();
				if (items_sent > CALM_AFTER)
					calm = 1'b1;
			end
			phase++;
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
hw/rtl/aigd_pkg.sv
hw/rtl/aigd_cfg_regs.sv
hw/rtl/aigd_step.sv
hw/rtl/aigd_out_reg.sv
hw/rtl/aig_binary_and_delta_decoder.sv
dv/aigd_gate_checker.sv
dv/aig_binary_and_delta_decoder_tb.sv
